// ----- rtl/core/run_length_byte_codec_core_defines.svh -----
// ---------------------------------------------------------------------------
// Run-length byte codec: assertion macros
// Property shorthands for the codec's port checker.
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_BYTE_CODEC_CORE_DEFINES_SVH
`define RUN_LENGTH_BYTE_CODEC_CORE_DEFINES_SVH

// same-cycle implication
`define RLBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rlbc_pkg.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec package
// Widths and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package rlbc_pkg;

  localparam int BYTE_W     = 8;
  localparam int OUT_W      = 64;
  localparam int CNT_W      = 4;
  localparam int RESULT_CAP = 32;

  typedef struct packed {
    logic load;
    logic emit;
  } rlbc_cmd_t;

  typedef struct packed {
    logic work;
    logic slot_free;
    logic final_word;
  } rlbc_sts_t;

endpackage

// ----- rtl/core/rlbc_in_if.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec input channel
// One stream byte per word, with end-of-stream flag.
// ---------------------------------------------------------------------------
interface rlbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/core/rlbc_out_if.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec output channel
// Up to eight packed bytes per word, with byte count and last flag.
// ---------------------------------------------------------------------------
interface rlbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  out_valid_count;
  logic        out_last;

  modport source (output valid, output out_bytes, output out_valid_count,
                  output out_last, input ready);
  modport sink   (input valid, input out_bytes, input out_valid_count,
                  input out_last, output ready);
endinterface

// ----- rtl/core/rlbc_ctrl.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec controller
// Sequences input loads and output word emission.
// ---------------------------------------------------------------------------
module rlbc_ctrl
  import rlbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rlbc_sts_t sts,
  output rlbc_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd.load  = in_valid && in_ready;
    cmd.emit  = (state_r == ST_EMIT) && sts.slot_free;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load && sts.work) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.emit && sts.final_word) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/rlbc_datapath.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec datapath
// Stream state, pending byte buffer, word packer and output register.
// ---------------------------------------------------------------------------
module rlbc_datapath
  import rlbc_pkg::*;
#(
  parameter int MAX_RUN   = 255,
  parameter int OUT_LANES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  rlbc_cmd_t          cmd,
  output rlbc_sts_t          sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [OUT_W-1:0]   out_bytes,
  output logic [CNT_W-1:0]   out_valid_count,
  output logic               out_last
);

  localparam int               CAP_I    = RESULT_CAP * OUT_LANES;
  localparam logic [BYTE_W-1:0] MaxRunB = BYTE_W'(MAX_RUN);
  localparam logic [BYTE_W-1:0] LanesB  = BYTE_W'(OUT_LANES);
  localparam logic [BYTE_W-1:0] CapB    = (CAP_I > 255) ? 8'd255 : BYTE_W'(CAP_I);
  localparam int               SHIFT    = BYTE_W * OUT_LANES;

  // stream state
  logic              mode_r;
  logic [BYTE_W-1:0] run_val_r;
  logic [BYTE_W-1:0] run_len_r;
  logic              pair_half_r;
  logic [BYTE_W-1:0] held_r;

  // pending bytes of the current word
  logic [BYTE_W-1:0] rem_r;
  logic              rep_r;
  logic [BYTE_W-1:0] rep_val_r;
  logic [OUT_W-1:0]  pend_r;
  logic              plast_r;

  // output register
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_bytes_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;

  logic              run_open, close_prev, close_new;
  logic [BYTE_W-1:0] len_new, val_new, held_cap, exp_n, load_n, word_cnt;
  logic [2:0]        cmp_n;
  logic [31:0]       pend_load;
  logic [OUT_W-1:0]  word;

  always_comb begin
    run_open   = (run_len_r != '0);
    close_prev = run_open && ((in_byte != run_val_r) || (run_len_r >= MaxRunB));
    if (close_prev || !run_open) begin
      len_new = 8'd1;
      val_new = in_byte;
    end else begin
      len_new = run_len_r + 8'd1;
      val_new = run_val_r;
    end
    close_new = (len_new >= MaxRunB) || in_last;
    pend_load = {val_new, len_new,
                 (close_prev ? {run_val_r, run_len_r} : {val_new, len_new})};
    cmp_n     = {close_prev & close_new, close_prev ^ close_new, 1'b0};
    held_cap  = (held_r > CapB) ? CapB : held_r;
    exp_n     = pair_half_r ? held_cap : '0;
    load_n    = mode_r ? {5'b0, cmp_n} : exp_n;
  end

  always_comb begin
    word_cnt = (rem_r > LanesB) ? LanesB : rem_r;
    word     = '0;
    for (int k = 0; k < 8; k++) begin
      if ((k < OUT_LANES) && (BYTE_W'(k) < rem_r)) begin
        word[8*k +: 8] = rep_r ? rep_val_r : pend_r[8*k +: 8];
      end
    end
  end

  assign sts.work       = (load_n != '0) || in_last;
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.final_word = (rem_r <= LanesB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      run_val_r   <= '0;
      run_len_r   <= '0;
      pair_half_r <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r      <= cfg_wr_data;
        run_val_r   <= '0;
        run_len_r   <= '0;
        pair_half_r <= 1'b0;
        held_r      <= '0;
      end else if (cmd.load) begin
        if (in_last) begin
          run_val_r   <= '0;
          run_len_r   <= '0;
          pair_half_r <= 1'b0;
          held_r      <= '0;
        end else if (mode_r) begin
          run_len_r <= close_new ? '0 : len_new;
          run_val_r <= val_new;
        end else if (!pair_half_r) begin
          held_r      <= in_byte;
          pair_half_r <= 1'b1;
        end else begin
          held_r      <= '0;
          pair_half_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r     <= load_n;
      rep_r     <= !mode_r;
      rep_val_r <= in_byte;
      pend_r    <= {32'b0, pend_load};
      plast_r   <= in_last;
    end else if (cmd.emit) begin
      rem_r  <= rem_r - word_cnt;
      pend_r <= pend_r >> SHIFT;
    end
    if (cmd.emit) begin
      out_bytes_r <= word;
      out_cnt_r   <= word_cnt[CNT_W-1:0];
      out_last_r  <= plast_r && sts.final_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bytes       = out_bytes_r;
  assign out_valid_count = out_cnt_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/core/run_length_byte_codec_core.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec core
// Compresses bytes into (count, value) pairs or expands pairs into runs.
// ---------------------------------------------------------------------------
// channel   dir  payload                                    handshake
// in_if     in   in_byte[7:0], in_last                      valid/ready
// out_if    out  out_bytes[63:0], out_valid_count, out_last valid/ready
// cfg       in   cfg_wr_data (compress_mode)                cfg_wr_en
//
// A byte that makes no word is only loaded; otherwise it is loaded and then
// packed into ceil(n/OUT_LANES) words for n output bytes (one word for the last byte with nothing to send).
// The word packer emits one word per cycle from the pending buffer while the output register has room.
// The output register lets the next byte in while the last word waits.
// Output stalls hold the packer; reset is synchronous, active low.
// ---------------------------------------------------------------------------
module run_length_byte_codec_core
  import rlbc_pkg::*;
#(
  parameter int MAX_RUN   = 255,
  parameter int OUT_LANES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  rlbc_in_if.sink     in_if,
  rlbc_out_if.source  out_if,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  rlbc_cmd_t cmd;
  rlbc_sts_t sts;

  rlbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlbc_datapath #(
    .MAX_RUN   (MAX_RUN),
    .OUT_LANES (OUT_LANES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_if.in_byte),
    .in_last         (in_if.in_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_bytes       (out_if.out_bytes),
    .out_valid_count (out_if.out_valid_count),
    .out_last        (out_if.out_last)
  );

endmodule

// ----- rtl/core/rlbc_checker.sv -----
// ---------------------------------------------------------------------------
// Run-length byte codec port checker
// Watches the output channel of the core; bound to the top level.
// ---------------------------------------------------------------------------
`include "run_length_byte_codec_core_defines.svh"

module rlbc_checker #(
  parameter int OUT_LANES = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bytes,
  input logic [3:0]  out_valid_count,
  input logic        out_last
);

  `RLBC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bytes) && $stable(out_valid_count) && $stable(out_last), "stalled word changed")
  `RLBC_ASSERT_IMP(a_cnt_range, clk, rst_n, out_valid, out_valid_count <= 4'(OUT_LANES), "byte count above lane count")
  `RLBC_ASSERT_IMP(a_empty_last, clk, rst_n, out_valid && (out_valid_count == 4'd0), out_last && (out_bytes == 64'd0), "empty word not last or not zero")
  `RLBC_ASSERT_IMP(a_tail_zero, clk, rst_n, out_valid && (out_valid_count < 4'd8), (out_bytes >> {out_valid_count, 3'b000}) == 64'd0, "lanes past count not zero")

endmodule

bind run_length_byte_codec_core rlbc_checker #(.OUT_LANES(OUT_LANES)) u_rlbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_bytes       (out_if.out_bytes),
  .out_valid_count (out_if.out_valid_count),
  .out_last        (out_if.out_last)
);
